### hw/rtl/msw_pkg.sv
// Shared types, constants and helpers for the 3x3 max-sum window locator.
// No dependencies; every other file of the block but msw_ram imports this package.
`default_nettype none

package msw_pkg;

  localparam int MAX_COLUMNS    = 1024;
  localparam int ELEMENT_BITS   = 16;
  localparam int ROW_LIMIT      = 1024;
  localparam int WIN            = 3;
  localparam int WIN_CELLS      = WIN * WIN;
  localparam int SUM_BITS       = ELEMENT_BITS + 4;
  localparam int COL_BITS       = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS       = $clog2(ROW_LIMIT);
  localparam int LINE_BITS      = 2 * ELEMENT_BITS;
  localparam int CELL_IDX_BITS  = $clog2(WIN_CELLS);
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int Q_DEPTH        = 3;
  localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [SUM_BITS-1:0]     sum_t;
  typedef logic [ROW_BITS-1:0]            row_t;
  typedef logic [COL_BITS-1:0]            col_t;
  typedef logic [LINE_BITS-1:0]           line_t;
  typedef logic [CFG_DATA_BITS-1:0]       cfg_data_t;
  typedef logic [CFG_INDEX_BITS-1:0]      cfg_index_t;
  typedef logic [CELL_IDX_BITS-1:0]       cell_idx_t;
  typedef logic [Q_CNT_BITS-1:0]          q_cnt_t;

  localparam cfg_index_t REG_ROW_COUNT    = cfg_index_t'(0);
  localparam cfg_index_t REG_COLUMN_COUNT = cfg_index_t'(1);

  localparam cfg_data_t ROW_COUNT_RESET    = cfg_data_t'(3);
  localparam cfg_data_t COLUMN_COUNT_RESET = cfg_data_t'(3);

  typedef struct packed {
    logic       we;
    cfg_index_t index;
    cfg_data_t  data;
  } cfg_wr_t;

  // One finished frame: best window in row-major order plus its position
  typedef struct packed {
    logic                       found;
    sum_t                       sum;
    row_t                       row;
    col_t                       col;
    elem_t [WIN_CELLS-1:0]      win;
  } snap_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } push_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } qhead_t;

  // Last index of a count: zero reads as one, large values saturate at limit
  function automatic int unsigned count_last(cfg_data_t v, int unsigned limit);
    int unsigned n;
    n = int'(v);
    if (n == 0) begin
      return 0;
    end
    if (n > limit) begin
      return limit - 1;
    end
    return n - 1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/msw_in_if.sv
// Element input channel: valid/ready handshake carrying one matrix element.
// Depends on msw_pkg for the element type.
`default_nettype none

interface msw_in_if;
  import msw_pkg::*;

  logic  valid;
  logic  ready;
  elem_t element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/msw_out_if.sv
// Result channel: valid/ready handshake carrying one element of the best window.
// Depends on msw_pkg for the field types.
`default_nettype none

interface msw_out_if;
  import msw_pkg::*;

  logic  valid;
  logic  ready;
  elem_t window_element;
  sum_t  best_sum;
  row_t  best_row;
  col_t  best_column;
  logic  found;
  logic  last_of_run;

  modport source (output valid, output window_element, output best_sum, output best_row,
                  output best_column, output found, output last_of_run, input ready);
  modport sink   (input valid, input window_element, input best_sum, input best_row,
                  input best_column, input found, input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/msw_ram.sv
// Generic single-write, single-read RAM with registered read (read-old on collision).
// No dependencies.
`default_nettype none

module msw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/msw_front.sv
// Front end: takes elements, runs the line stores and 3x3 window, sums and keeps the best.
// Depends on msw_pkg, msw_in_if and msw_ram; pushes finished frames towards the queue.
`default_nettype none

module msw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  msw_pkg::cfg_wr_t cfg_wr,
  msw_in_if.sink          in_chan,
  input  msw_pkg::q_cnt_t q_free,
  output msw_pkg::push_t  push
);
  import msw_pkg::*;

  // configuration, held as last row / last column index
  row_t  rows_last_r;
  col_t  cols_last_r;

  col_t  col_r, col_nxt;
  row_t  row_r, row_nxt;
  logic  acc, rdy, pend;
  logic  last_col, last_row;

  // line store: entry holds {row r-2, row r-1} for a column
  col_t  ram_rd_addr;
  line_t ram_rd_data, entry, wr_entry;
  logic  byp_sel_r;
  line_t byp_data_r;
  elem_t up, mid, e;

  elem_t win_r [WIN_CELLS];
  sum_t  col_sum;
  sum_t  cs1_r, cs2_r, pair_r;

  logic  s1_valid_r, s1_check_r, s1_last_r;
  row_t  s1_row_r;
  col_t  s1_col_r;

  sum_t  win_sum;
  logic  better;
  logic  have_best_r, have_best_nxt;
  sum_t  best_sum_r, best_sum_nxt;
  row_t  best_row_r, best_row_nxt;
  col_t  best_col_r, best_col_nxt;
  elem_t best_win_r [WIN_CELLS];
  elem_t best_win_nxt [WIN_CELLS];

  // hold off input while a pending frame end could find the queue full
  assign pend          = s1_valid_r && s1_last_r;
  assign rdy           = q_free > q_cnt_t'(pend);
  assign in_chan.ready = rdy;
  assign acc           = in_chan.valid && rdy;
  assign e             = in_chan.element_value;

  assign last_col = col_r >= cols_last_r;
  assign last_row = row_r >= rows_last_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= row_t'(count_last(ROW_COUNT_RESET, ROW_LIMIT));
      cols_last_r <= col_t'(count_last(COLUMN_COUNT_RESET, MAX_COLUMNS));
    end else if (cfg_wr.we) begin
      case (cfg_wr.index)
        REG_ROW_COUNT: begin
          rows_last_r <= row_t'(count_last(cfg_wr.data, ROW_LIMIT));
        end
        REG_COLUMN_COUNT: begin
          cols_last_r <= col_t'(count_last(cfg_wr.data, MAX_COLUMNS));
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the entry of the next column; bypass when it is the one just written
  assign ram_rd_addr = rst_n ? col_nxt : '0;
  assign entry       = byp_sel_r ? byp_data_r : ram_rd_data;
  assign up          = entry[LINE_BITS-1:ELEMENT_BITS];
  assign mid         = entry[ELEMENT_BITS-1:0];
  assign wr_entry    = {mid, e};

  msw_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .we      (acc),
    .wr_addr (col_r),
    .wr_data (wr_entry),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign col_sum = sum_t'(up) + sum_t'(mid) + sum_t'(e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      byp_sel_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s1_check_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      byp_sel_r  <= acc && (col_nxt == col_r);
      s1_valid_r <= acc;
      if (acc) begin
        s1_check_r <= (row_r >= row_t'(WIN - 1)) && (col_r >= col_t'(WIN - 1));
        s1_last_r  <= last_col && last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byp_data_r <= wr_entry;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_r[WIN*i+j] <= win_r[WIN*i+j+1];
        end
      end
      win_r[WIN-1]     <= up;
      win_r[2*WIN-1]   <= mid;
      win_r[3*WIN-1]   <= e;
      // column sums of the last two columns, paired ahead of the window sum
      pair_r   <= cs1_r + cs2_r;
      cs1_r    <= cs2_r;
      cs2_r    <= col_sum;
      s1_row_r <= row_r - row_t'(WIN - 1);
      s1_col_r <= col_r - col_t'(WIN - 1);
    end
  end

  assign win_sum = pair_r + cs2_r;
  assign better  = s1_valid_r && s1_check_r && (!have_best_r || (win_sum > best_sum_r));

  always_comb begin
    have_best_nxt = have_best_r || better;
    best_sum_nxt  = better ? win_sum  : best_sum_r;
    best_row_nxt  = better ? s1_row_r : best_row_r;
    best_col_nxt  = better ? s1_col_r : best_col_r;
    for (int k = 0; k < WIN_CELLS; k++) begin
      best_win_nxt[k] = better ? win_r[k] : best_win_r[k];
    end
  end

  always_comb begin
    push.valid      = pend;
    push.snap.found = have_best_nxt;
    push.snap.sum   = best_sum_nxt;
    push.snap.row   = best_row_nxt;
    push.snap.col   = best_col_nxt;
    for (int k = 0; k < WIN_CELLS; k++) begin
      push.snap.win[k] = best_win_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else begin
      // drop the running best once the frame has been handed on
      have_best_r <= pend ? 1'b0 : have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_sum_r <= best_sum_nxt;
    best_row_r <= best_row_nxt;
    best_col_r <= best_col_nxt;
    for (int k = 0; k < WIN_CELLS; k++) begin
      best_win_r[k] <= best_win_nxt[k];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/msw_queue.sv
// Short queue of finished frames between the front end and the result emitter.
// Depends on msw_pkg.
`default_nettype none

module msw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  msw_pkg::push_t   push,
  input  logic             pop,
  output msw_pkg::qhead_t  head,
  output msw_pkg::q_cnt_t  free
);
  import msw_pkg::*;

  snap_t                  slot_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  q_cnt_t                 count_r;

  function automatic logic [Q_PTR_BITS-1:0] ptr_inc(logic [Q_PTR_BITS-1:0] p);
    return (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push.valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.snap;
    end
  end

  assign head.valid = count_r != '0;
  assign head.snap  = slot_r[rd_ptr_r];
  assign free       = q_cnt_t'(Q_DEPTH) - count_r;

endmodule

`default_nettype wire

### hw/rtl/msw_emit.sv
// Result emitter: walks the nine cells of the head frame (one word if it has no window) into a registered output.
// Depends on msw_pkg and msw_out_if.
`default_nettype none

module msw_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  msw_pkg::qhead_t  head,
  output logic             pop,
  msw_out_if.source        out_chan
);
  import msw_pkg::*;

  logic      out_valid_r;
  cell_idx_t idx_r;
  elem_t     elem_r;
  sum_t      sum_r;
  row_t      row_r;
  col_t      col_r;
  logic      found_r, last_r;
  logic      load, last_word;

  assign load      = head.valid && (!out_valid_r || out_chan.ready);
  // a frame without a window gives a single word
  assign last_word = !head.snap.found || (idx_r == cell_idx_t'(WIN_CELLS - 1));
  assign pop       = load && last_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last_word ? '0 : idx_r + 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      elem_r  <= head.snap.found ? head.snap.win[idx_r] : '0;
      sum_r   <= head.snap.found ? head.snap.sum : '0;
      row_r   <= head.snap.found ? head.snap.row : '0;
      col_r   <= head.snap.found ? head.snap.col : '0;
      found_r <= head.snap.found;
      last_r  <= last_word;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.window_element = elem_r;
  assign out_chan.best_sum       = sum_r;
  assign out_chan.best_row       = row_r;
  assign out_chan.best_column    = col_r;
  assign out_chan.found          = found_r;
  assign out_chan.last_of_run    = last_r;

endmodule

`default_nettype wire

### hw/rtl/max_sum_3x3_window_locator.sv
// Top level of the 3x3 max-sum window locator: front end, frame queue, result emitter.
// Depends on msw_pkg, msw_in_if, msw_out_if, msw_front, msw_queue and msw_emit.
//
//   channel  | direction | handshake         | word
//   in_chan  | in        | valid/ready       | element_value
//   out_chan | out       | valid/ready       | window_element, best_sum, best_row,
//            |           |                   | best_column, found, last_of_run
//   cfg_*    | in        | cfg_we, no ready  | cfg_index, cfg_data
//
// One element is taken every cycle that in_chan.ready is high; the line store is one RAM
// read and one write a cycle. Result words leave from a registered output, one word
// per cycle while out_chan is ready: nine words per frame, or one with no full window.
// Input stalls only when a frame end would leave no free slot in the three-slot frame
// queue, which happens only while result words are held off.
// Synchronous active-low reset clears control state; line store contents stay undefined.
`default_nettype none

module max_sum_3x3_window_locator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  msw_pkg::cfg_index_t   cfg_index,
  input  msw_pkg::cfg_data_t    cfg_data,
  msw_in_if.sink                in_chan,
  msw_out_if.source             out_chan
);
  import msw_pkg::*;

  cfg_wr_t cfg_wr;
  push_t   push;
  qhead_t  head;
  q_cnt_t  q_free;
  logic    pop;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  msw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .in_chan (in_chan),
    .q_free  (q_free),
    .push    (push)
  );

  msw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .free  (q_free)
  );

  msw_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
